[sv/text_console_glyph_renderer_macros.svh]
// assertion macros used by the console renderer sequencer
`ifndef TEXT_CONSOLE_GLYPH_RENDERER_MACROS_SVH
`define TEXT_CONSOLE_GLYPH_RENDERER_MACROS_SVH

// same-cycle implication, disabled during reset
`define TCGR_ASSERT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define TCGR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/tcgr_pkg.sv]
// shared constants and types of the console glyph renderer
package tcgr_pkg;

   localparam int GLYPH_WIDTH  = 8;
   localparam int GLYPH_HEIGHT = 16;
   localparam int GLYPH_COUNT  = 256;
   localparam int STORE_DEPTH  = 4096;

   localparam int ADDR_W = $clog2(STORE_DEPTH);
   localparam int CNT_W  = $clog2(GLYPH_HEIGHT + 1);
   localparam int COL_W  = 8;
   localparam int X_W    = 11;
   localparam int Y_W    = 12;
   localparam int BITS_W = 8;
   localparam int CODE_W = 16;
   localparam int OP_W   = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 32;

   // operations
   localparam logic [OP_W-1:0] OP_PRINT      = 2'd0;
   localparam logic [OP_W-1:0] OP_SET_CURSOR = 2'd1;
   localparam logic [OP_W-1:0] OP_LOAD_GLYPH = 2'd2;

   // character codes
   localparam logic [CODE_W-1:0] CODE_CR    = 16'd13;
   localparam logic [CODE_W-1:0] CODE_LF    = 16'd10;
   localparam logic [CODE_W-1:0] CODE_NUL   = 16'd0;
   localparam logic [CODE_W-1:0] CODE_SPACE = 16'd32;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_COLUMNS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FG_COLOR = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BG_COLOR = 2'd3;

   localparam logic [COL_W-1:0] COLUMNS_RESET = 8'd128;
   localparam logic [COL_W-1:0] ROWS_RESET    = 8'd48;

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_ROWS   = 3'b010,
      S_SCROLL = 3'b100
   } tcgr_state_type;

   typedef struct packed {
      logic [COL_W-1:0] columns;
      logic [COL_W-1:0] rows;
   } tcgr_geom_type;

   typedef struct packed {
      logic              kind;
      logic [X_W-1:0]    pixel_x;
      logic [Y_W-1:0]    pixel_y;
      logic [BITS_W-1:0] row_bits;
      logic              last;
   } tcgr_result_type;

endpackage

[sv/tcgr_ram.sv]
// generic single-write single-read synchronous ram with registered read
module tcgr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

[sv/tcgr_seq.sv]
// cursor keeping and glyph row sequencer around the glyph store
`include "text_console_glyph_renderer_macros.svh"

module tcgr_seq (
   input  logic                        clock,
   input  logic                        reset,
   input  tcgr_pkg::tcgr_geom_type     geom,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [tcgr_pkg::OP_W-1:0]   req_op,
   input  logic [tcgr_pkg::CODE_W-1:0] req_code,
   input  logic [tcgr_pkg::COL_W-1:0]  req_col,
   input  logic [tcgr_pkg::COL_W-1:0]  req_line,
   input  logic [tcgr_pkg::ADDR_W-1:0] req_addr,
   input  logic [tcgr_pkg::BITS_W-1:0] req_byte,
   output logic                        out_valid,
   input  logic                        out_ready,
   output tcgr_pkg::tcgr_result_type   out_result
);
   import tcgr_pkg::*;

   tcgr_state_type    state_ff, state_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [COL_W-1:0]  row_ff, row_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              pend_ff, pend_in;
   logic              pend_last_ff, pend_last_in;
   logic [Y_W-1:0]    pend_y_ff, pend_y_in;
   logic              scroll_ff, scroll_in;
   logic [Y_W-1:0]    scroll_y_ff, scroll_y_in;
   logic [ADDR_W-1:0] base_addr_ff, base_addr_in;
   logic [X_W-1:0]    x_ff, x_in;
   logic [Y_W-1:0]    base_y_ff, base_y_in;

   logic [COL_W-1:0]  eff_cols, eff_rows;
   logic              req_fire, slot_free;
   logic              step_scroll;
   logic [COL_W-1:0]  step_row;
   logic [Y_W-1:0]    step_y;
   logic [CODE_W-1:0] code_eff, glyph;
   logic [31:0]       glyph_base;
   logic [15:0]       x_full, y_full, scroll_full;
   logic              wr_en, rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [BITS_W-1:0] rd_data;

   tcgr_ram #(.WIDTH(BITS_W), .DEPTH(STORE_DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (req_addr),
      .wr_data (req_byte),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      eff_cols = (geom.columns == '0) ? COL_W'(1) : geom.columns;
      eff_rows = (geom.rows < COL_W'(2)) ? COL_W'(2) : geom.rows;
      req_ready = (state_ff == S_IDLE);
      req_fire  = req_valid && req_ready;
      slot_free = !pend_ff || out_ready;

      // one row down, or a scroll at the bottom
      step_scroll = ({1'b0, row_ff} + 9'd1) >= {1'b0, eff_rows};
      step_row    = step_scroll ? (eff_rows - COL_W'(1)) : (row_ff + COL_W'(1));
      scroll_full = 16'(eff_rows - COL_W'(1)) * 16'(GLYPH_HEIGHT);
      step_y      = scroll_full[Y_W-1:0];

      code_eff   = (req_code == CODE_NUL) ? CODE_SPACE : req_code;
      glyph      = (32'(code_eff) < 32'(GLYPH_COUNT)) ? code_eff : '0;
      glyph_base = 32'(glyph) * 32'(GLYPH_HEIGHT);
      x_full     = 16'(col_ff) * 16'(GLYPH_WIDTH);
      y_full     = 16'(row_ff) * 16'(GLYPH_HEIGHT);

      rd_addr = base_addr_ff + ADDR_W'(cnt_ff);
      wr_en   = 1'b0;
      rd_en   = 1'b0;

      state_in     = state_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      cnt_in       = cnt_ff;
      pend_in      = pend_ff;
      pend_last_in = pend_last_ff;
      pend_y_in    = pend_y_ff;
      scroll_in    = scroll_ff;
      scroll_y_in  = scroll_y_ff;
      base_addr_in = base_addr_ff;
      x_in         = x_ff;
      base_y_in    = base_y_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req_op)
                  OP_SET_CURSOR: begin
                     col_in = (req_col > eff_cols - COL_W'(1)) ? eff_cols - COL_W'(1) : req_col;
                     row_in = (req_line > eff_rows - COL_W'(1)) ? eff_rows - COL_W'(1)
                                                                : req_line;
                  end
                  OP_LOAD_GLYPH: begin
                     wr_en = 1'b1;
                  end
                  OP_PRINT: begin
                     if (req_code == CODE_CR) begin
                        col_in = '0;
                     end else if (req_code == CODE_LF) begin
                        col_in      = '0;
                        row_in      = step_row;
                        scroll_y_in = step_y;
                        if (step_scroll) begin
                           state_in = S_SCROLL;
                        end
                     end else begin
                        base_addr_in = glyph_base[ADDR_W-1:0];
                        x_in         = x_full[X_W-1:0];
                        base_y_in    = y_full[Y_W-1:0];
                        cnt_in       = '0;
                        state_in     = S_ROWS;
                        if (({1'b0, col_ff} + 9'd1) >= {1'b0, eff_cols}) begin
                           col_in      = '0;
                           row_in      = step_row;
                           scroll_in   = step_scroll;
                           scroll_y_in = step_y;
                        end else begin
                           col_in    = col_ff + COL_W'(1);
                           scroll_in = 1'b0;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_ROWS: begin
            if (cnt_ff != CNT_W'(GLYPH_HEIGHT)) begin
               if (slot_free) begin
                  rd_en        = 1'b1;
                  pend_in      = 1'b1;
                  pend_y_in    = base_y_ff + Y_W'(cnt_ff);
                  pend_last_in = (cnt_ff == CNT_W'(GLYPH_HEIGHT - 1)) && !scroll_ff;
                  cnt_in       = cnt_ff + CNT_W'(1);
               end
            end else if (slot_free) begin
               pend_in  = 1'b0;
               state_in = scroll_ff ? S_SCROLL : S_IDLE;
            end
         end
         S_SCROLL: begin
            if (out_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      out_valid = pend_ff || (state_ff == S_SCROLL);
      if (state_ff == S_SCROLL) begin
         out_result.kind     = 1'b1;
         out_result.pixel_x  = '0;
         out_result.pixel_y  = scroll_y_ff;
         out_result.row_bits = '0;
         out_result.last     = 1'b1;
      end else begin
         out_result.kind     = 1'b0;
         out_result.pixel_x  = x_ff;
         out_result.pixel_y  = pend_y_ff;
         out_result.row_bits = rd_data;
         out_result.last     = pend_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         col_ff   <= '0;
         row_ff   <= COL_W'(1);
         cnt_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         cnt_ff   <= cnt_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_last_ff <= pend_last_in;
      pend_y_ff    <= pend_y_in;
      scroll_ff    <= scroll_in;
      scroll_y_ff  <= scroll_y_in;
      base_addr_ff <= base_addr_in;
      x_ff         <= x_in;
      base_y_ff    <= base_y_in;
   end

   `TCGR_ASSERT(a_cnt_range, clock, reset, 1'b1, cnt_ff <= CNT_W'(GLYPH_HEIGHT), "row count overran")
   `TCGR_ASSERT(a_pend_in_rows, clock, reset, pend_ff, state_ff == S_ROWS, "row data outside print")
   `TCGR_ASSERT_NEXT(a_read_held, clock, reset, rd_en, pend_ff, "read data not presented")
   `TCGR_ASSERT(a_write_idle, clock, reset, wr_en, state_ff == S_IDLE, "store written while busy")

endmodule

[sv/text_console_glyph_renderer.sv]
// text console glyph renderer: top level with register port and result stage
//
// character-cell console renderer. each request carries an operation in
// req_tuser: print a code, set the cursor, or load one glyph byte into the
// 4096 x 8 glyph store. a print sends out one result per glyph pixel row
// (16 of them), at most one per cycle, and one scroll command after them
// when the cursor passes the bottom row; carriage return, set cursor and
// glyph loads give no result. the glyph store has a single read port, so a
// print occupies the block while it takes the request, reads the glyph rows
// in turn and drains the last one, then sends any scroll; a newline with a
// scroll waits until it is taken, others do not, and the next request can
// follow in the next cycle. the result register lets a finished result wait
// while the block already takes the next request. glyph entries must be
// loaded before they are printed; there is no clearing pass after reset.
// the colour registers are accepted on the csr port but no result field
// depends on them: the pixel sink applies the colours
module text_console_glyph_renderer (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // char_code[15:0], cursor_col[23:16], cursor_line[31:24],
   // glyph_addr[43:32], glyph_byte[51:44], zero pad[55:52]
   input  logic [tcgr_pkg::REQ_DATA_W-1:0]  req_tdata,
   // operation[1:0]
   input  logic [tcgr_pkg::OP_W-1:0]        req_tuser,
   // result channel
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // pixel_x[10:0], pixel_y[22:11], row_bits[30:23], zero pad[31]
   output logic [tcgr_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // kind[0]
   output logic                             rsp_tuser,
   output logic                             rsp_tlast,
   // configuration write channel
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [tcgr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tcgr_pkg::CSR_DATA_W-1:0]  csr_data
);
   import tcgr_pkg::*;

   // screen geometry registers
   logic [COL_W-1:0] columns_ff, columns_in;
   logic [COL_W-1:0] rows_ff, rows_in;
   tcgr_geom_type    geom;

   // result stage
   logic             rsp_valid_ff, rsp_valid_in;
   tcgr_result_type  rsp_result_ff, rsp_result_in;

   logic             seq_valid, seq_ready;
   tcgr_result_type  seq_result;

   // register writes are always taken
   assign csr_ready = 1'b1;

   always_comb begin
      columns_in = columns_ff;
      rows_in    = rows_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index) inside
            CSR_COLUMNS: columns_in = csr_data[COL_W-1:0];
            CSR_ROWS:    rows_in    = csr_data[COL_W-1:0];
            // colours only matter to the pixel sink
            CSR_FG_COLOR, CSR_BG_COLOR: ;
            default: ;
         endcase
      end
   end

   assign geom.columns = columns_ff;
   assign geom.rows    = rows_ff;

   tcgr_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .geom       (geom),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_op     (req_tuser),
      .req_code   (req_tdata[15:0]),
      .req_col    (req_tdata[23:16]),
      .req_line   (req_tdata[31:24]),
      .req_addr   (req_tdata[43:32]),
      .req_byte   (req_tdata[51:44]),
      .out_valid  (seq_valid),
      .out_ready  (seq_ready),
      .out_result (seq_result)
   );

   // result register: refills in the cycle it is emptied
   always_comb begin
      seq_ready     = !rsp_valid_ff || rsp_tready;
      rsp_valid_in  = rsp_valid_ff;
      rsp_result_in = rsp_result_ff;
      if (seq_ready) begin
         rsp_valid_in  = seq_valid;
         rsp_result_in = seq_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         columns_ff   <= COLUMNS_RESET;
         rows_ff      <= ROWS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         columns_ff   <= columns_in;
         rows_ff      <= rows_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_result_ff <= rsp_result_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_result_ff.row_bits, rsp_result_ff.pixel_y,
                        rsp_result_ff.pixel_x};
   assign rsp_tuser  = rsp_result_ff.kind;
   assign rsp_tlast  = rsp_result_ff.last;

endmodule
